// File: hw/rtl/tscbr_pkg.sv
// tscbr_pkg: shared types and constants of the cbr transport stream pacer
// used by the channel interfaces and by ts_cbr_pacer_with_null_stuffing
// no dependencies
package tscbr_pkg;

  // field widths of the channels and the configuration port
  localparam int OP_W      = 2;
  localparam int ELAPSED_W = 20;
  localparam int KIND_W    = 2;
  localparam int SLOT_O_W  = 15;
  localparam int PCNT_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 30;

  // register widths
  localparam int CSLOTS_W  = 16;
  localparam int THRESH_W  = 16;
  localparam int PPD_W     = 7;
  localparam int RATE_W    = 30;
  localparam int FILL_W    = 16;
  localparam int SLOTS_W   = 17;  // holds a slot count up to 65536
  localparam int PROD_W    = ELAPSED_W + RATE_W;
  localparam int COST_PKT_W = 31;
  localparam int COST_W    = PPD_W + COST_PKT_W;
  localparam int CREDIT_W  = 64;

  // parameter defaults
  localparam int MAX_SLOTS_DEF    = 32768;
  localparam int MAX_PER_TICK_DEF = 16;
  localparam int PACKET_BYTES_DEF = 188;

  localparam int US_PER_S = 1000000;
  localparam int PPD_MAX  = 64;

  localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  // register reset values
  localparam logic [CSLOTS_W-1:0] CSLOTS_RST = 16'd30000;
  localparam logic [THRESH_W-1:0] THRESH_RST = 16'd10000;
  localparam logic [PPD_W-1:0]    PPD_RST    = 7'd7;
  localparam logic [RATE_W-1:0]   RATE_RST   = 30'd100000000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_IDLE  = 2'd2,
    OP_EOF   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 2'd0,
    KIND_NULL    = 2'd1,
    KIND_WR_OK   = 2'd2,
    KIND_WR_FULL = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_SLOTS = 2'd0,
    CFG_THRESHOLD   = 2'd1,
    CFG_PPD         = 2'd2,
    CFG_BITRATE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WR   = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_STEP = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

endpackage

// File: hw/rtl/tscbr_ifs.sv
// tscbr_ifs: valid/ready channel interfaces of the cbr pacer
// tscbr_in_if carries requests, tscbr_out_if carries result beats
// depends on tscbr_pkg
interface tscbr_in_if import tscbr_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [ELAPSED_W-1:0] elapsed_us;
  logic                 idle_flag;

  modport source (output valid, op, elapsed_us, idle_flag, input ready);
  modport sink   (input valid, op, elapsed_us, idle_flag, output ready);
endinterface

interface tscbr_out_if import tscbr_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_O_W-1:0] first_slot;
  logic [PCNT_W-1:0]   packet_count;
  logic                last;

  modport source (output valid, kind, first_slot, packet_count, last, input ready);
  modport sink   (input valid, kind, first_slot, packet_count, last, output ready);
endinterface

// File: hw/rtl/ts_cbr_pacer_with_null_stuffing.sv
// ts_cbr_pacer_with_null_stuffing: ring bookkeeping and bit-credit pacing of a cbr
// transport stream sender; depends on tscbr_pkg and tscbr_ifs
//
// A user sees one request at a time: in_ch.ready is high only while the sequencer is
// idle, and a result beat may still wait in the output register then. A write request
// is accepted and then answered; set-idle and end-of-file are done on acceptance. A
// tick is accepted, multiplied and added to the credit, then per datagram runs a
// credit check and an emit, a data datagram also a slot step per packet between them,
// because the read pointer is stepped through the ring by a single slot incrementer,
// one slot per cycle, to keep the wrap rule exact; a tick that sends no datagram ends
// with the failed credit check. The credit uses one shared 64-bit adder for the tick's
// addition and for every datagram charge. Stalls on out_ch.ready hold S_WR and S_EMIT.
module ts_cbr_pacer_with_null_stuffing
  import tscbr_pkg::*;
#(
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int MAX_PER_TICK = MAX_PER_TICK_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tscbr_in_if.sink             in_ch,
  tscbr_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int NCNT_W = $clog2(MAX_PER_TICK + 1);
  localparam logic [SLOTS_W-1:0]    MAX_SLOTS_V = SLOTS_W'(MAX_SLOTS);
  localparam logic [NCNT_W-1:0]     MAX_TICK_V  = NCNT_W'(MAX_PER_TICK);
  localparam logic [COST_PKT_W-1:0] COST_PKT    = COST_PKT_W'(PACKET_BYTES * 8 * US_PER_S);

  // configuration
  logic [CSLOTS_W-1:0] cslots_r;
  logic [THRESH_W-1:0] thresh_r;
  logic [PPD_W-1:0]    ppd_r;
  logic [RATE_W-1:0]   rate_r;

  // control state
  state_t                     state_r, state_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [SLOT_W-1:0]          wslot_r, wslot_nxt;
  logic [SLOT_W-1:0]          rslot_r, rslot_nxt;
  logic                       ready_flag_r, ready_flag_nxt;
  logic                       src_idle_r, src_idle_nxt;
  logic signed [CREDIT_W-1:0] credit_r, credit_nxt;
  logic [NCNT_W-1:0]          n_r, n_nxt;
  logic [PCNT_W-1:0]          step_r, step_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // payload
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [PROD_W-1:0]    prod_r;
  logic [COST_W-1:0]    cost_r;
  kind_t                pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic [PCNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [SLOT_O_W-1:0]  out_slot_r, out_slot_nxt;
  logic [PCNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                       in_fire;
  logic                       out_free;
  logic [SLOTS_W-1:0]         slots;
  logic [PPD_W-1:0]           ppd_eff;
  logic signed [CREDIT_W-1:0] addend;
  logic signed [CREDIT_W-1:0] credit_sum;
  logic                       more;
  logic [FILL_W:0]            fill_inc;
  logic [PCNT_W-1:0]          take;

  function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] slot,
                                                input logic [SLOTS_W-1:0] nslots);
    logic [SLOTS_W-1:0] n;
    n = SLOTS_W'(slot) + SLOTS_W'(1);
    return (n >= nslots) ? '0 : SLOT_W'(n);
  endfunction

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.first_slot   = out_slot_r;
  assign out_ch.packet_count = out_cnt_r;
  assign out_ch.last         = out_last_r;

  assign slots    = ({1'b0, cslots_r} > MAX_SLOTS_V) ? MAX_SLOTS_V : {1'b0, cslots_r};
  assign ppd_eff  = (ppd_r == '0) ? PPD_W'(1) :
                    (ppd_r > PPD_W'(PPD_MAX)) ? PPD_W'(PPD_MAX) : ppd_r;
  assign fill_inc = {1'b0, fill_r} + (FILL_W+1)'(1);
  assign take     = (fill_r < FILL_W'(ppd_eff)) ? PCNT_W'(fill_r) : ppd_eff;
  assign more     = (credit_r > 64'sd0) && (n_r < MAX_TICK_V);

  // shared credit adder: tick addition in S_ADD, datagram charge otherwise
  assign addend     = (state_r == S_ADD) ? signed'({{(CREDIT_W-PROD_W){1'b0}}, prod_r})
                                         : -signed'({{(CREDIT_W-COST_W){1'b0}}, cost_r});
  assign credit_sum = credit_r + addend;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    wslot_nxt      = wslot_r;
    rslot_nxt      = rslot_r;
    ready_flag_nxt = ready_flag_r;
    src_idle_nxt   = src_idle_r;
    credit_nxt     = credit_r;
    n_nxt          = n_r;
    step_nxt       = step_r;
    pend_kind_nxt  = pend_kind_r;
    pend_slot_nxt  = pend_slot_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_ch.op))
            OP_WRITE: state_nxt = S_WR;
            OP_TICK:  state_nxt = S_MUL;
            OP_IDLE:  src_idle_nxt = in_ch.idle_flag;
            OP_EOF:   ready_flag_nxt = 1'b0;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (fill_inc >= slots) begin
            out_kind_nxt = KIND_WR_FULL;
            out_slot_nxt = '0;
          end else begin
            out_kind_nxt = KIND_WR_OK;
            out_slot_nxt = SLOT_O_W'(wslot_r);
            wslot_nxt    = advance(wslot_r, slots);
            fill_nxt     = FILL_W'(fill_inc);
            if (FILL_W'(fill_inc) > thresh_r) ready_flag_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        n_nxt     = '0;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        credit_nxt = (credit_sum > CREDIT_MAX) ? CREDIT_MAX : credit_sum;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (more) begin
          credit_nxt = credit_sum;
          n_nxt      = n_r + NCNT_W'(1);
          if ((ready_flag_r || src_idle_r) && (fill_r != '0)) begin
            pend_kind_nxt = KIND_DATA;
            pend_slot_nxt = rslot_r;
            pend_cnt_nxt  = take;
            step_nxt      = take;
            fill_nxt      = fill_r - FILL_W'(take);
            state_nxt     = S_STEP;
          end else begin
            pend_kind_nxt = KIND_NULL;
            pend_slot_nxt = '0;
            pend_cnt_nxt  = ppd_eff;
            state_nxt     = S_EMIT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_STEP: begin
        rslot_nxt = advance(rslot_r, slots);
        step_nxt  = step_r - PCNT_W'(1);
        if (step_r == PCNT_W'(1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_slot_nxt  = SLOT_O_W'(pend_slot_r);
          out_cnt_nxt   = pend_cnt_r;
          out_last_nxt  = !more;
          state_nxt     = more ? S_CHK : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      wslot_r      <= '0;
      rslot_r      <= '0;
      ready_flag_r <= 1'b0;
      src_idle_r   <= 1'b0;
      credit_r     <= '0;
      n_r          <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      cslots_r     <= CSLOTS_RST;
      thresh_r     <= THRESH_RST;
      ppd_r        <= PPD_RST;
      rate_r       <= RATE_RST;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      wslot_r      <= wslot_nxt;
      rslot_r      <= rslot_nxt;
      ready_flag_r <= ready_flag_nxt;
      src_idle_r   <= src_idle_nxt;
      credit_r     <= credit_nxt;
      n_r          <= n_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CACHE_SLOTS: cslots_r <= cfg_wdata[CSLOTS_W-1:0];
          CFG_THRESHOLD:   thresh_r <= cfg_wdata[THRESH_W-1:0];
          CFG_PPD:         ppd_r    <= cfg_wdata[PPD_W-1:0];
          CFG_BITRATE:     rate_r   <= cfg_wdata[RATE_W-1:0];
          default:         rate_r   <= rate_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) elapsed_r <= in_ch.elapsed_us;
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(elapsed_r * rate_r);
      cost_r <= COST_W'(ppd_eff * COST_PKT);
    end
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  // a data datagram always moves at least one packet, so the slot walk never starts empty
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> step_r != '0)
    else $error("slot walk running with zero packets left");

  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_TICK_V)
    else $error("datagrams per tick above limit");

  a_credit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CREDIT_MAX)
    else $error("credit above saturation limit");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_DATA |->
      out_cnt_r != '0 && out_cnt_r <= PCNT_W'(PPD_MAX))
    else $error("data datagram packet count out of range");

  // a failed check ends the tick without another beat
  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK && !more |=> state_r == S_IDLE)
    else $error("tick did not finish after failed credit check");

endmodule

// File: bench/ts_cbr_pacer_with_null_stuffing_tb.sv
// testbench of ts_cbr_pacer_with_null_stuffing: a directed table, then random phases,
// each beat checked against an in-bench model of ring bookkeeping and credit pacing
// depends on tscbr_pkg, tscbr_ifs and the rtl of the pacer
`timescale 1ns / 1ps

module ts_cbr_pacer_with_null_stuffing_tb;
  import tscbr_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RAND_ITEMS     = 185;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int EL_MAX         = 20'hFFFFF;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_O_W-1:0] slot;
    logic [PCNT_W-1:0]   cnt;
    logic                last;
  } beat_t;

  typedef struct {
    bit                 is_reg;
    cfg_idx_t           idx;
    logic [CFG_DW-1:0]  val;
    op_t                op;
    logic [ELAPSED_W-1:0] el;
    logic               idl;
    bit                 typed;
    beat_t              lit;
  } row_t;

  localparam beat_t NO_BEAT = '0;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_DW-1:0]    cfg_wdata;

  tscbr_in_if  in_ch();
  tscbr_out_if out_ch();

  ts_cbr_pacer_with_null_stuffing i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // register copies
  logic [CSLOTS_W-1:0] slots_reg  = CSLOTS_RST;
  logic [THRESH_W-1:0] thresh_reg = THRESH_RST;
  logic [PPD_W-1:0]    ppd_reg    = PPD_RST;
  logic [RATE_W-1:0]   rate_reg   = RATE_RST;

  // ring and credit state
  int unsigned fill_cnt   = 0;
  int unsigned wr_slot    = 0;
  int unsigned rd_slot    = 0;
  bit          ready_flag = 1'b0;
  bit          src_idle   = 1'b0;
  longint      credit     = 0;

  beat_t due_beats[$];
  row_t  plan[$];

  int    err_count    = 0;
  int    quiet_cycles = 0;
  int    holds_asked  = 0;
  int    holds_done   = 0;
  bit    tx_steady    = 1'b0;
  bit    rx_steady    = 1'b0;
  bit    lit_on       = 1'b0;
  beat_t lit_beat     = '0;

  function automatic int unsigned eff_ppd();
    if (ppd_reg == 0) return 1;
    if (ppd_reg > PPD_MAX) return PPD_MAX;
    return ppd_reg;
  endfunction

  function automatic longint dgram_cost(int unsigned ppd);
    return longint'(ppd) * PACKET_BYTES_DEF * 8 * US_PER_S;
  endfunction

  function automatic int unsigned next_slot(int unsigned s, int unsigned slots);
    return (s + 1 >= slots) ? 0 : s + 1;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // works out the beats one request causes and advances the ring and credit
  task automatic pace_item(input op_t op, input logic [ELAPSED_W-1:0] el, input logic idl);
    int unsigned slots, ppd, cnt, n;
    longint      cost;
    beat_t       b;
    slots = (slots_reg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : slots_reg;
    ppd   = eff_ppd();
    cost  = dgram_cost(ppd);
    case (op)
      OP_WRITE: begin
        if (fill_cnt + 1 >= slots) begin
          due_beats.push_back('{KIND_WR_FULL, '0, '0, 1'b1});
        end else begin
          due_beats.push_back('{KIND_WR_OK, SLOT_O_W'(wr_slot), '0, 1'b1});
          wr_slot  = next_slot(wr_slot, slots);
          fill_cnt = (fill_cnt + 1) & 16'hFFFF;
          if (fill_cnt > thresh_reg) ready_flag = 1'b1;
        end
      end
      OP_IDLE: src_idle = idl;
      OP_EOF:  ready_flag = 1'b0;
      default: begin
        credit = credit + longint'(el) * longint'(rate_reg);
        if (credit > CREDIT_MAX) credit = CREDIT_MAX;
        n = 0;
        while (credit > 0 && n < MAX_PER_TICK_DEF) begin
          if ((ready_flag || src_idle) && fill_cnt > 0) begin
            cnt = (fill_cnt < ppd) ? fill_cnt : ppd;
            b = '{KIND_DATA, SLOT_O_W'(rd_slot), PCNT_W'(cnt), 1'b0};
            repeat (cnt) rd_slot = next_slot(rd_slot, slots);
            fill_cnt -= cnt;
          end else begin
            b = '{KIND_NULL, '0, PCNT_W'(ppd), 1'b0};
          end
          credit -= cost;
          n++;
          b.last = !(credit > 0 && n < MAX_PER_TICK_DEF);
          due_beats.push_back(b);
        end
      end
    endcase
  endtask

  function automatic void add_item(op_t op, logic [ELAPSED_W-1:0] el, logic idl,
                                   bit typed, beat_t lit);
    row_t r;
    r = '{1'b0, CFG_CACHE_SLOTS, '0, op, el, idl, typed, lit};
    plan.push_back(r);
  endfunction

  function automatic void add_reg(cfg_idx_t idx, logic [CFG_DW-1:0] val);
    row_t r;
    r = '{1'b1, idx, val, OP_WRITE, '0, 1'b0, 1'b0, NO_BEAT};
    plan.push_back(r);
  endfunction

  task automatic offer(input op_t op, input logic [ELAPSED_W-1:0] el, input logic idl,
                       input bit typed, input beat_t lit);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.elapsed_us <= el;
    in_ch.idle_flag  <= idl;
    lit_on           <= typed;
    lit_beat         <= lit;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait until every due beat has come, then let a tick with no result finish
  task automatic settle_out();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_CACHE_SLOTS: slots_reg  = val[CSLOTS_W-1:0];
      CFG_THRESHOLD:   thresh_reg = val[THRESH_W-1:0];
      CFG_PPD:         ppd_reg    = val[PPD_W-1:0];
      default:         rate_reg   = val[RATE_W-1:0];
    endcase
  endtask

  initial begin : stim
    row_t                 r;
    int                   p, n, k, pick, wr_bias;
    longint               lim, rdiv;
    logic [CSLOTS_W-1:0]  s_val;
    logic [THRESH_W-1:0]  t_val;
    logic [PPD_W-1:0]     d_val;
    logic [RATE_W-1:0]    b_val;
    logic [CFG_DW-1:0]    junk;
    logic [ELAPSED_W-1:0] el;
    op_t                  op;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_WRITE;
    in_ch.elapsed_us <= '0;
    in_ch.idle_flag  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_CACHE_SLOTS;
    cfg_wdata        <= '0;

    // reset settings first, then the register extremes
    add_item(OP_TICK, 0, 0, 0, NO_BEAT);
    add_item(OP_WRITE, 0, 0, 1, '{KIND_WR_OK, 15'd0, 7'd0, 1'b1});
    add_item(OP_WRITE, 20'hFFFFF, 1, 1, '{KIND_WR_OK, 15'd1, 7'd0, 1'b1});
    add_item(OP_TICK, 1, 0, 1, '{KIND_NULL, 15'd0, 7'd7, 1'b1});
    add_item(OP_IDLE, 0, 1, 0, NO_BEAT);
    add_item(OP_TICK, 200, 0, 0, NO_BEAT);
    // more credit than the per-tick cap spends, rest carries to the next tick
    add_item(OP_TICK, 1700, 0, 0, NO_BEAT);
    add_item(OP_TICK, 0, 0, 0, NO_BEAT);
    add_item(OP_EOF, 0, 0, 0, NO_BEAT);
    add_item(OP_IDLE, 0, 0, 0, NO_BEAT);
    add_reg(CFG_CACHE_SLOTS, 30'h3FFF_FFFF);
    add_reg(CFG_THRESHOLD, 30'h3FFF_0000);
    add_reg(CFG_PPD, 30'h3FFF_FF80);
    add_reg(CFG_BITRATE, 30'd1);
    add_item(OP_TICK, 20'hFFFFF, 1, 0, NO_BEAT);
    add_item(OP_TICK, 20'd1000000, 0, 0, NO_BEAT);
    add_item(OP_WRITE, 0, 0, 0, NO_BEAT);
    add_reg(CFG_BITRATE, 30'h3FFF_FFFF);
    // ready stays set after the ring drains, so nulls follow the data
    add_item(OP_TICK, 20, 0, 0, NO_BEAT);
    add_item(OP_WRITE, 0, 0, 0, NO_BEAT);
    add_item(OP_WRITE, 0, 0, 0, NO_BEAT);
    add_item(OP_TICK, 3, 0, 0, NO_BEAT);
    add_reg(CFG_PPD, 30'h0000_007F);
    add_reg(CFG_CACHE_SLOTS, 30'd1);
    add_item(OP_WRITE, 0, 0, 1, '{KIND_WR_FULL, 15'd0, 7'd0, 1'b1});
    add_reg(CFG_CACHE_SLOTS, 30'd0);
    add_item(OP_WRITE, 0, 0, 1, '{KIND_WR_FULL, 15'd0, 7'd0, 1'b1});
    // write pointer sits past a shrunken ring and wraps
    add_reg(CFG_CACHE_SLOTS, 30'd3);
    add_reg(CFG_THRESHOLD, 30'h3FFF_FFFF);
    add_item(OP_WRITE, 0, 0, 0, NO_BEAT);
    add_item(OP_WRITE, 0, 0, 0, NO_BEAT);
    add_item(OP_WRITE, 0, 0, 0, NO_BEAT);
    add_item(OP_IDLE, 0, 1, 0, NO_BEAT);
    add_item(OP_TICK, 100, 0, 0, NO_BEAT);
    add_item(OP_EOF, 0, 0, 0, NO_BEAT);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_reg) begin
        settle_out();
        write_reg(r.idx, r.val);
      end else begin
        offer(r.op, r.el, r.idl, r.typed, r.lit);
      end
    end

    n = 0;
    p = 0;
    while (n < RAND_ITEMS) begin
      settle_out();
      s_val = CSLOTS_W'($urandom_range(2, 40));
      t_val = THRESH_W'($urandom_range(0, s_val + 2));
      d_val = PPD_W'($urandom_range(1, 9));
      b_val = RATE_W'($urandom_range(1000000, 1000000000));
      case (p % 8)
        0: begin s_val = 16'hFFFF; t_val = '0; end
        1: begin s_val = 16'd2; d_val = 7'h7F; end
        2: begin s_val = '0; d_val = '0; end
        3: begin t_val = 16'hFFFF; b_val = 30'h3FFF_FFFF; end
        4: d_val = 7'd64;
        5: b_val = 30'd1;
        6: b_val = '0;
        default: ;
      endcase
      junk = CFG_DW'($urandom);
      write_reg(CFG_CACHE_SLOTS, {junk[CFG_DW-1:CSLOTS_W], s_val});
      write_reg(CFG_THRESHOLD, {junk[CFG_DW-1:THRESH_W], t_val});
      write_reg(CFG_PPD, {junk[CFG_DW-1:PPD_W], d_val});
      write_reg(CFG_BITRATE, b_val);
      if (p == 0 || $urandom_range(0, 4) == 0) holds_asked++;

      // tick lengths sized for up to three datagrams each, one in 25 ticks six times that
      rdiv = (rate_reg == 0) ? 1 : rate_reg;
      lim  = dgram_cost(eff_ppd()) * 3 / rdiv;
      if (lim > EL_MAX) lim = EL_MAX;
      if (lim < 1) lim = 1;
      wr_bias = $urandom_range(30, 65);
      for (k = $urandom_range(18, 32); k > 0; k--) begin
        pick = $urandom_range(0, 99);
        el   = ELAPSED_W'($urandom);
        if (pick < wr_bias) begin
          op = OP_WRITE;
        end else if (pick < 88) begin
          op = OP_TICK;
          if ($urandom_range(0, 24) == 0) el = ELAPSED_W'((lim * 6 > EL_MAX) ? EL_MAX : lim * 6);
          else el = ELAPSED_W'($urandom_range(0, 32'(lim)));
        end else if (pick < 94) begin
          op = OP_IDLE;
        end else begin
          op = OP_EOF;
        end
        offer(op, el, $urandom_range(0, 1), 1'b0, NO_BEAT);
        n++;
      end
      p++;
    end
    settle_out();

    if (err_count == 0) begin
      $display("ts_cbr_pacer_with_null_stuffing_tb: done, clean");
    end else begin
      $display("ts_cbr_pacer_with_null_stuffing_tb: done, errors");
    end
    $finish;
  end

  initial begin : rx_pace
    int gap, run;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds_done != holds_asked) begin
        // long back-pressure so the block fills and stalls its input
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        gap = pick_gap(rx_steady);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin : mon
    beat_t got, want;
    bit    in_acc, out_acc;
    in_acc  = rst_n && in_ch.valid && in_ch.ready;
    out_acc = rst_n && out_ch.valid && out_ch.ready;
    if (in_acc) begin
      pace_item(op_t'(in_ch.op), in_ch.elapsed_us, in_ch.idle_flag);
      if (lit_on && due_beats.size() > 0) due_beats[due_beats.size() - 1] = lit_beat;
    end
    if (out_acc) begin
      got = '{kind_t'(out_ch.kind), out_ch.first_slot, out_ch.packet_count, out_ch.last};
      if (due_beats.size() == 0) begin
        err_count++;
        $display("%0t: beat with none due, got kind=%0d slot=%0d cnt=%0d last=%0d",
                 $time, got.kind, got.slot, got.cnt, got.last);
      end else begin
        want = due_beats.pop_front();
        if (got !== want) begin
          err_count++;
          $display("%0t: beat mismatch, expected kind=%0d slot=%0d cnt=%0d last=%0d",
                   $time, want.kind, want.slot, want.cnt, want.last);
          $display("%0t:                  actual kind=%0d slot=%0d cnt=%0d last=%0d",
                   $time, got.kind, got.slot, got.cnt, got.last);
        end
      end
    end
    if (in_acc || out_acc || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("ts_cbr_pacer_with_null_stuffing_tb: done, errors");
      $finish;
    end
  end

endmodule
